@@ hw/rtl/qs3c_pkg.sv @@
// Shared types, register codes and helper functions of the smallest-three quaternion compressor.
package qs3c_pkg;

	// Width of one quantized code and of the configuration data bus.
	localparam int CODE_WIDTH = 16;
	localparam int CFG_WIDTH  = 16;
	localparam int CFG_INDEX_WIDTH = 2;

	// Fixed-point positions of the quantizer.
	localparam int SCALE_SHIFT = 15;
	localparam int UNIT_FRAC   = 31;
	localparam int ROUND_BIT   = 30;
	localparam int SCALED_WIDTH = 48;

	// Packed word widths.
	localparam int LOW_WIDTH  = 32;
	localparam int HIGH_WIDTH = 16;

	// Layout of the packed result words.
	typedef enum logic [1:0] {
		FMT_FIELDS  = 2'd0,
		FMT_NINE    = 2'd1,
		FMT_TEN     = 2'd2,
		FMT_FIFTEEN = 2'd3
	} pack_fmt_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_PACK_FORMAT    = 2'd0,
		REG_COMPONENT_BITS = 2'd1,
		REG_RANGE_BOUND    = 2'd2,
		REG_INVERSE_SPAN   = 2'd3
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam pack_fmt_t   RST_PACK_FORMAT    = FMT_NINE;
	localparam logic [4:0]  RST_COMPONENT_BITS = 5'd9;
	localparam logic [14:0] RST_RANGE_BOUND    = 15'd23170;
	localparam logic [15:0] RST_INVERSE_SPAN   = 16'd46341;

	// Load enables of the lane pipeline stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Largest code value, 2^n - 1, for the selected layout.
	function automatic logic [CODE_WIDTH-1:0] code_top(input pack_fmt_t fmt,
		input logic [4:0] bits);
		logic [4:0] n;
		logic [CODE_WIDTH:0] full;
		unique case (fmt)
			FMT_NINE:    n = 5'd9;
			FMT_TEN:     n = 5'd10;
			FMT_FIFTEEN: n = 5'd15;
			default: begin
				if (bits == 5'd0) begin
					n = 5'd1;
				end else if (bits > 5'd16) begin
					n = 5'd16;
				end else begin
					n = bits;
				end
			end
		endcase
		full = (17'd1 << n) - 17'd1;
		return full[CODE_WIDTH-1:0];
	endfunction

endpackage

@@ hw/rtl/qs3c_select.sv @@
// Finds the component of largest magnitude, the first one winning a tie.
module qs3c_select #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic [3:0][COMPONENT_WIDTH-1:0] comp,
	output logic [1:0]                      largest_idx,
	output logic                            largest_positive
);
	import qs3c_pkg::*;

	logic [3:0][COMPONENT_WIDTH:0] mag;
	logic [COMPONENT_WIDTH:0] mag_a;
	logic [COMPONENT_WIDTH:0] mag_b;
	logic [1:0] idx_a;
	logic [1:0] idx_b;

	// Magnitudes, one bit wider so the most negative value is exact.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (comp[i][COMPONENT_WIDTH-1]) begin
				mag[i] = -{1'b1, comp[i]};
			end else begin
				mag[i] = {1'b0, comp[i]};
			end
		end
	end

	// Two-level compare tree; a strict compare keeps the earlier index on a tie.
	always_comb begin
		if (mag[1] > mag[0]) begin
			idx_a = 2'd1;
			mag_a = mag[1];
		end else begin
			idx_a = 2'd0;
			mag_a = mag[0];
		end
		if (mag[3] > mag[2]) begin
			idx_b = 2'd3;
			mag_b = mag[3];
		end else begin
			idx_b = 2'd2;
			mag_b = mag[2];
		end
		if (mag_b > mag_a) begin
			largest_idx = idx_b;
		end else begin
			largest_idx = idx_a;
		end
	end

	assign largest_positive = ~comp[largest_idx][COMPONENT_WIDTH-1];

endmodule

@@ hw/rtl/qs3c_lane.sv @@
// One quantizer lane: sign fold, offset, scale by the reciprocal span, round and saturate.
module qs3c_lane #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                                clk,
	input  qs3c_pkg::stage_en_t                 en,
	input  logic [COMPONENT_WIDTH-1:0]          comp,
	input  logic                                negate,
	input  logic [14:0]                         range_bound,
	input  logic [15:0]                         inverse_span,
	input  logic [qs3c_pkg::CODE_WIDTH-1:0]     top,
	output logic [qs3c_pkg::CODE_WIDTH-1:0]     code
);
	import qs3c_pkg::*;

	localparam int OFF_WIDTH  = COMPONENT_WIDTH + 16;
	localparam int PROD_WIDTH = COMPONENT_WIDTH + 31;

	logic [COMPONENT_WIDTH:0] comp_ext;
	logic [COMPONENT_WIDTH:0] folded;
	logic [OFF_WIDTH-1:0]     offset_next;
	logic [OFF_WIDTH-1:0]     offset_s2;
	logic                     offset_pos;
	logic [PROD_WIDTH-1:0]    prod;
	logic [UNIT_FRAC:0]       unit_next;
	logic [UNIT_FRAC:0]       unit_s3;
	logic [SCALED_WIDTH-1:0]  scaled;
	logic [CODE_WIDTH:0]      rounded;
	logic [CODE_WIDTH-1:0]    code_next;
	logic [CODE_WIDTH-1:0]    code_s4;

	// Stage 2: fold the sign of the dropped component and shift onto the positive range.
	always_comb begin
		comp_ext = {comp[COMPONENT_WIDTH-1], comp};
		folded = negate ? -comp_ext : comp_ext;
		offset_next = {folded, {SCALE_SHIFT{1'b0}}}
			+ {2'b00, range_bound, {(COMPONENT_WIDTH-1){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			offset_s2 <= offset_next;
		end
	end

	// Stage 3: multiply by the reciprocal span to reach a unit value in Q.31.
	always_comb begin
		offset_pos = ~offset_s2[OFF_WIDTH-1] && (offset_s2 != '0);
		prod = PROD_WIDTH'(offset_s2[OFF_WIDTH-2:0]) * PROD_WIDTH'(inverse_span);
		unit_next = offset_pos ? prod[PROD_WIDTH-1:COMPONENT_WIDTH-1] : '0;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			unit_s3 <= unit_next;
		end
	end

	// Stage 4: scale to the code range, round half up and saturate at the top code.
	always_comb begin
		scaled = SCALED_WIDTH'(unit_s3) * SCALED_WIDTH'(top)
			+ (SCALED_WIDTH'(1) << ROUND_BIT);
		rounded = scaled[SCALED_WIDTH-1:UNIT_FRAC];
		code_next = (rounded > {1'b0, top}) ? top : rounded[CODE_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			code_s4 <= code_next;
		end
	end

	assign code = code_s4;

endmodule

@@ hw/rtl/qs3c_pack.sv @@
// Merges the three lane codes, index and sign into the packed words of the selected layout.
module qs3c_pack (
	input  qs3c_pkg::pack_fmt_t                    fmt,
	input  logic [2:0][qs3c_pkg::CODE_WIDTH-1:0]   code,
	input  logic [1:0]                             largest_idx,
	input  logic                                   largest_positive,
	output logic [qs3c_pkg::LOW_WIDTH-1:0]         packed_low,
	output logic [qs3c_pkg::HIGH_WIDTH-1:0]        packed_high
);
	import qs3c_pkg::*;

	// Codes never exceed the layout's top value, so the part-selects lose nothing.
	// The nine-bit word keeps bit 29 clear between the index and the sign.
	always_comb begin
		unique case (fmt)
			FMT_NINE: begin
				packed_low = {1'b0, largest_positive, 1'b0, largest_idx,
					code[2][8:0], code[1][8:0], code[0][8:0]};
				packed_high = '0;
			end
			FMT_TEN: begin
				packed_low = {largest_idx, code[2][9:0], code[1][9:0], code[0][9:0]};
				packed_high = '0;
			end
			FMT_FIFTEEN: begin
				packed_low = {largest_idx, code[1][14:0], code[0][14:0]};
				packed_high = {largest_positive, code[2][14:0]};
			end
			default: begin
				packed_low = '0;
				packed_high = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/quat_smallest_three_compress_unit.sv @@
// Top level of the smallest-three quaternion compressor: registers, lane pipeline and output stage.
//
// Channel   Direction  Contents
// s_*       in         one quaternion per transaction, four signed components
// m_*       out        three codes, dropped index, sign flag, packed words
// cfg_*     in         register writes: pack_format, component_bits, range_bound, inverse_span
//
// One quaternion enters per cycle unless m_tready back-pressure has filled every stage.
// The pipeline is select (s1), offset (s2), span multiply (s3), code multiply (s4), pack (s5).
// Each stage loads when it is empty or the stage after it moves, so bubbles are squeezed out
// and, while any stage is empty, a transaction is taken as a finished result waits on m_tready.
// arst_n clears the stage valid bits and sets the registers to their reset values.
module quat_smallest_three_compress_unit #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// quat_x, quat_y, quat_z, quat_w from the lowest bit, zero padded to bytes
	input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// code_first, code_second, code_third, dropped_index, largest_positive,
	// packed_low, packed_high from the lowest bit, zero padded to bytes
	output logic [103:0]                           m_tdata,
	input  logic                                   cfg_we,
	input  logic [qs3c_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [qs3c_pkg::CFG_WIDTH-1:0]         cfg_wdata
);
	import qs3c_pkg::*;

	localparam int OUT_FIELDS = 3*CODE_WIDTH + 2 + 1 + LOW_WIDTH + HIGH_WIDTH;

	// Configuration registers.
	pack_fmt_t   pack_format_q;
	logic [4:0]  component_bits_q;
	logic [14:0] range_bound_q;
	logic [15:0] inverse_span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_format_q <= RST_PACK_FORMAT;
			component_bits_q <= RST_COMPONENT_BITS;
			range_bound_q <= RST_RANGE_BOUND;
			inverse_span_q <= RST_INVERSE_SPAN;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PACK_FORMAT:    pack_format_q <= pack_fmt_t'(cfg_wdata[1:0]);
				REG_COMPONENT_BITS: component_bits_q <= cfg_wdata[4:0];
				REG_RANGE_BOUND:    range_bound_q <= cfg_wdata[14:0];
				REG_INVERSE_SPAN:   inverse_span_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage valid bits and load enables, from the output side back.
	logic v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic en_s1, en_out;
	stage_en_t lane_en;

	always_comb begin
		en_out = ~v_out_q | m_tready;
		lane_en.s4 = ~v_s4 | en_out;
		lane_en.s3 = ~v_s3 | lane_en.s4;
		lane_en.s2 = ~v_s2 | lane_en.s3;
		en_s1 = ~v_s1 | lane_en.s2;
	end

	assign s_tready = en_s1;
	assign m_tvalid = v_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (lane_en.s2) v_s2 <= v_s1;
			if (lane_en.s3) v_s3 <= v_s2;
			if (lane_en.s4) v_s4 <= v_s3;
			if (en_out) v_out_q <= v_s4;
		end
	end

	// Stage 1: register the components together with the largest one's index and sign.
	logic [3:0][COMPONENT_WIDTH-1:0] comp_in;
	logic [1:0] idx_in;
	logic       pos_in;

	assign comp_in = s_tdata[4*COMPONENT_WIDTH-1:0];

	qs3c_select #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_select (
		.comp            (comp_in),
		.largest_idx     (idx_in),
		.largest_positive(pos_in)
	);

	logic [3:0][COMPONENT_WIDTH-1:0] comp_s1;
	logic [1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic       pos_s1, pos_s2, pos_s3, pos_s4;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			comp_s1 <= comp_in;
			idx_s1 <= idx_in;
			pos_s1 <= pos_in;
		end
		if (lane_en.s2) begin
			idx_s2 <= idx_s1;
			pos_s2 <= pos_s1;
		end
		if (lane_en.s3) begin
			idx_s3 <= idx_s2;
			pos_s3 <= pos_s2;
		end
		if (lane_en.s4) begin
			idx_s4 <= idx_s3;
			pos_s4 <= pos_s3;
		end
	end

	// The kept components in x,y,z,w order skip the dropped one.
	logic [2:0][COMPONENT_WIDTH-1:0] kept;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < idx_s1) begin
				kept[k] = comp_s1[k];
			end else begin
				kept[k] = comp_s1[k+1];
			end
		end
	end

	// Three quantizer lanes, stages 2 to 4.
	logic [CODE_WIDTH-1:0] top;
	logic [2:0][CODE_WIDTH-1:0] code_s4;

	assign top = code_top(pack_format_q, component_bits_q);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		qs3c_lane #(
			.COMPONENT_WIDTH(COMPONENT_WIDTH)
		) u_lane (
			.clk         (clk),
			.en          (lane_en),
			.comp        (kept[k]),
			.negate      (~pos_s1),
			.range_bound (range_bound_q),
			.inverse_span(inverse_span_q),
			.top         (top),
			.code        (code_s4[k])
		);
	end

	// Stage 5: pack and hold the result until the transaction completes.
	logic [LOW_WIDTH-1:0]  low_next;
	logic [HIGH_WIDTH-1:0] high_next;
	logic [OUT_FIELDS-1:0] out_q;

	qs3c_pack u_pack (
		.fmt             (pack_format_q),
		.code            (code_s4),
		.largest_idx     (idx_s4),
		.largest_positive(pos_s4),
		.packed_low      (low_next),
		.packed_high     (high_next)
	);

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q <= {high_next, low_next, pos_s4, idx_s4, code_s4[2], code_s4[1], code_s4[0]};
		end
	end

	assign m_tdata = {{(104-OUT_FIELDS){1'b0}}, out_q};

endmodule

@@ tb/quat_code_checker.sv @@
// Checker for the smallest-three quaternion compressor: predicts each result and compares it.
`timescale 1ns / 1ps

module quat_code_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [63:0]                          s_tdata,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [103:0]                         m_tdata,
	input  logic                                 cfg_we,
	input  logic [qs3c_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [qs3c_pkg::CFG_WIDTH-1:0]       cfg_wdata,
	output int                                   mismatch_count,
	output int                                   codes_pending,
	output int                                   codes_seen
);
	import qs3c_pkg::*;

	// One result transaction, highest field first so that it maps onto m_tdata.
	typedef struct packed {
		logic [4:0]  pad;
		logic [15:0] packed_high;
		logic [31:0] packed_low;
		logic        largest_positive;
		logic [1:0]  dropped_index;
		logic [15:0] code_third;
		logic [15:0] code_second;
		logic [15:0] code_first;
	} quat_code_t;

	// Shadow copy of the configuration registers.
	pack_fmt_t   layout_q;
	logic [4:0]  code_bits_q;
	logic [14:0] bound_q;
	logic [15:0] span_q;

	quat_code_t expected_codes[$];

	initial begin
		mismatch_count = 0;
		codes_pending  = 0;
		codes_seen     = 0;
	end

	// Maps one sign-corrected component onto 0..2^n-1 with half-up rounding and saturation.
	function automatic logic [15:0] quantize_lane(input longint v, input int n);
		longint top;
		longint offset;
		longint unit;
		longint code;
		top    = (64'sd1 <<< n) - 1;
		offset = v * 32768 + longint'(bound_q) * 32768;
		if (offset <= 0) begin
			return 16'd0;
		end
		unit = (offset * longint'(span_q)) >>> 15;
		code = (unit * top + (64'sd1 <<< 30)) >>> 31;
		if (code > top) begin
			code = top;
		end
		return code[15:0];
	endfunction

	// Full prediction of one result from one input quaternion.
	function automatic quat_code_t compress_quat(input logic [63:0] d);
		longint     comp [4];
		longint     mag;
		longint     best;
		int         lead;
		int         n;
		int         k;
		logic       pos;
		logic [15:0] codes [3];
		quat_code_t r;
		for (int i = 0; i < 4; i++) begin
			comp[i] = longint'($signed(d[16*i +: 16]));
		end
		// Largest magnitude wins; a tie keeps the earlier component.
		best = comp[0] < 0 ? -comp[0] : comp[0];
		lead = 0;
		for (int i = 1; i < 4; i++) begin
			mag = comp[i] < 0 ? -comp[i] : comp[i];
			if (mag > best) begin
				best = mag;
				lead = i;
			end
		end
		pos = comp[lead] >= 0;
		case (layout_q)
			FMT_NINE:    n = 9;
			FMT_TEN:     n = 10;
			FMT_FIFTEEN: n = 15;
			default: begin
				n = int'(code_bits_q);
				if (n < 1) n = 1;
				if (n > 16) n = 16;
			end
		endcase
		k = 0;
		for (int i = 0; i < 4; i++) begin
			if (i != lead) begin
				codes[k] = quantize_lane(pos ? comp[i] : -comp[i], n);
				k++;
			end
		end
		r = '0;
		r.code_first       = codes[0];
		r.code_second      = codes[1];
		r.code_third       = codes[2];
		r.dropped_index    = 2'(lead);
		r.largest_positive = pos;
		case (layout_q)
			FMT_NINE: begin
				r.packed_low = (32'(pos) << 30) | (32'(lead) << 27) | (32'(codes[2]) << 18) |
					(32'(codes[1]) << 9) | 32'(codes[0]);
			end
			FMT_TEN: begin
				r.packed_low = (32'(lead) << 30) | (32'(codes[2]) << 20) |
					(32'(codes[1]) << 10) | 32'(codes[0]);
			end
			FMT_FIFTEEN: begin
				r.packed_low  = (32'(lead) << 30) | (32'(codes[1]) << 15) | 32'(codes[0]);
				r.packed_high = (16'(pos) << 15) | codes[2];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Counts one field mismatch and reports the first few of them.
	task automatic check_field(input string fname, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("Mismatch on %s of result %0d: expected 0x%0h, got 0x%0h", fname,
					codes_seen, want, got);
			end
		end
	endtask

	// Tracks register writes, predicts each input transaction and checks each result.
	always @(posedge clk or negedge arst_n) begin
		quat_code_t want;
		quat_code_t got;
		if (!arst_n) begin
			layout_q    = RST_PACK_FORMAT;
			code_bits_q = RST_COMPONENT_BITS;
			bound_q     = RST_RANGE_BOUND;
			span_q      = RST_INVERSE_SPAN;
			expected_codes.delete();
			codes_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PACK_FORMAT:    layout_q    = pack_fmt_t'(cfg_wdata[1:0]);
					REG_COMPONENT_BITS: code_bits_q = cfg_wdata[4:0];
					REG_RANGE_BOUND:    bound_q     = cfg_wdata[14:0];
					REG_INVERSE_SPAN:   span_q      = cfg_wdata[15:0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_codes.push_back(compress_quat(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				got = quat_code_t'(m_tdata);
				if (expected_codes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Result with no quaternion waiting: 0x%0h", m_tdata);
					end
				end else begin
					want = expected_codes.pop_front();
					check_field("code_first", 32'(want.code_first), 32'(got.code_first));
					check_field("code_second", 32'(want.code_second), 32'(got.code_second));
					check_field("code_third", 32'(want.code_third), 32'(got.code_third));
					check_field("dropped_index", 32'(want.dropped_index),
						32'(got.dropped_index));
					check_field("largest_positive", 32'(want.largest_positive),
						32'(got.largest_positive));
					check_field("packed_low", want.packed_low, got.packed_low);
					check_field("packed_high", 32'(want.packed_high), 32'(got.packed_high));
					check_field("padding", 32'(want.pad), 32'(got.pad));
				end
				codes_seen++;
			end
			codes_pending = expected_codes.size();
		end
	end

endmodule

@@ tb/quat_smallest_three_compress_unit_tb.sv @@
// Testbench top for the smallest-three quaternion compressor: stimulus, idling and verdict.
`timescale 1ns / 1ps

module quat_smallest_three_compress_unit_tb;
	import qs3c_pkg::*;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	// quat_x, quat_y, quat_z, quat_w from the lowest bit
	logic [63:0]                s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	// code_first, code_second, code_third, dropped_index, largest_positive,
	// packed_low, packed_high from the lowest bit, zero padded
	logic [103:0]               m_tdata;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0]       cfg_wdata;

	logic quiet;
	int   mismatch_count;
	int   codes_pending;
	int   codes_seen;
	int   quats_sent;
	int   settings_used;
	int   cur_bound;

	quat_smallest_three_compress_unit #(
		.COMPONENT_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	quat_code_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count),
		.codes_pending(codes_pending),
		.codes_seen(codes_seen)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", codes_pending);
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver back-pressure: about one stalled cycle in ten outside the quiet stretch.
	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(0, 99) >= 10);
	end

	function automatic logic [63:0] quat_word(input int x, input int y, input int z, input int w);
		return {16'(w), 16'(z), 16'(y), 16'(x)};
	endfunction

	// One random quaternion: raw noise, a unit-like shape, or edge values.
	function automatic logic [63:0] make_quat();
		int mode;
		int lead;
		int mag;
		int lim;
		int c [4];
		int specials [7];
		mode = $urandom_range(0, 9);
		specials = '{0, 1, -1, 32767, -32768, cur_bound, -cur_bound};
		if (mode < 4) begin
			return {$urandom, $urandom};
		end else if (mode < 9) begin
			lead = $urandom_range(0, 3);
			mag  = $urandom_range(16384, 32767);
			lim  = cur_bound < mag - 1 ? cur_bound : mag - 1;
			if (lim < 1) lim = 1;
			for (int i = 0; i < 4; i++) begin
				c[i] = (i == lead) ? mag : $urandom_range(0, lim);
				if ($urandom_range(0, 1) == 1) c[i] = -c[i];
			end
			if (c[lead] == -32767 && $urandom_range(0, 3) == 0) c[lead] = -32768;
		end else begin
			for (int i = 0; i < 4; i++) begin
				c[i] = specials[$urandom_range(0, 6)];
			end
		end
		return quat_word(c[0], c[1], c[2], c[3]);
	endfunction

	// Offers one quaternion, with random gaps, and returns once the transaction is taken.
	task automatic send_quat(input logic [63:0] d);
		logic taken;
		while (!quiet && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		quats_sent++;
	endtask

	// Stops the input and waits until every result is out and the pipeline has drained.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (codes_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Writes all four registers on consecutive cycles; called only while the block is idle.
	task automatic write_config(input pack_fmt_t layout, input logic [4:0] bits,
		input logic [14:0] bound, input logic [15:0] span);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PACK_FORMAT;
		cfg_wdata <= {14'($urandom), 2'(layout)};
		@(posedge clk);
		cfg_index <= REG_COMPONENT_BITS;
		cfg_wdata <= {11'($urandom), bits};
		@(posedge clk);
		cfg_index <= REG_RANGE_BOUND;
		cfg_wdata <= {1'b0, bound};
		@(posedge clk);
		cfg_index <= REG_INVERSE_SPAN;
		cfg_wdata <= span;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_bound = int'(bound);
		settings_used++;
	endtask

	// One block of random quaternions under the current settings.
	task automatic run_batch(input int count);
		for (int i = 0; i < count; i++) begin
			send_quat(make_quat());
		end
		settle();
	endtask

	// Span matched to the bound, clipped to the register width.
	function automatic logic [15:0] matched_span(input int bound);
		longint s;
		s = (64'sd1 <<< 30) / (bound > 0 ? bound : 1);
		return s > 65535 ? 16'hFFFF : 16'(s);
	endfunction

	// Stimulus and verdict.
	initial begin
		logic [63:0] directed [$];
		int          rb;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		m_tready      <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_PACK_FORMAT;
		cfg_wdata     <= '0;
		quiet         <= 1'b0;
		arst_n        <= 1'b0;
		quats_sent    = 0;
		settings_used = 1;
		cur_bound     = int'(RST_RANGE_BOUND);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases under the reset settings.
		directed.push_back(quat_word(0, 0, 0, 0));
		directed.push_back(quat_word(-32768, 32767, 32767, 32767));
		directed.push_back(quat_word(32767, -32768, 0, 0));
		directed.push_back(quat_word(16384, 16384, 0, 0));
		directed.push_back(quat_word(100, -200, 300, -30000));
		directed.push_back(quat_word(1000, 30000, -1000, 500));
		directed.push_back(quat_word(-1000, 500, -31000, 2000));
		directed.push_back(quat_word(0, 0, 0, 32767));
		directed.push_back(quat_word(10, -10, 5, -32768));
		directed.push_back(quat_word(32767, -32767, 32767, -32767));
		directed.push_back(quat_word(32767, 23170, -23170, 0));
		directed.push_back(quat_word(-1, -1, -1, -1));
		directed.push_back(quat_word(1, -1, 0, 1));
		directed.push_back(quat_word(-23170, 23170, 23169, -23171));
		directed.push_back(quat_word(20000, -20000, 20000, -20000));
		foreach (directed[i]) begin
			send_quat(directed[i]);
		end
		run_batch(100);

		// Ten-bit layout; the fifteen-bit pair runs without any idling on either side.
		write_config(FMT_TEN, 5'd9, 15'd23170, 16'd46341);
		run_batch(100);
		quiet <= 1'b1;
		write_config(FMT_FIFTEEN, 5'd9, 15'd23170, 16'd46341);
		run_batch(100);
		quiet <= 1'b0;

		// Generic widths at and beyond their limits, and extreme bound and span values.
		write_config(FMT_FIELDS, 5'd0, 15'd23170, 16'd46341);
		run_batch(80);
		write_config(FMT_FIELDS, 5'd16, 15'd32767, 16'd1);
		run_batch(80);
		write_config(FMT_FIELDS, 5'd31, 15'd1, 16'd65535);
		run_batch(80);
		write_config(FMT_FIELDS, 5'd1, 15'd0, 16'd0);
		run_batch(80);
		write_config(FMT_FIELDS, 5'd16, 15'd16384, 16'd65535);
		run_batch(80);

		// Random settings, mostly with a span that fits the bound.
		for (int p = 0; p < 4; p++) begin
			rb = $urandom_range(1, 32767);
			write_config(pack_fmt_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
				15'(rb), ($urandom_range(0, 3) == 0) ? 16'($urandom) : matched_span(rb));
			run_batch(75);
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d quaternions under %0d register settings, %0d results compared.",
			quats_sent, settings_used, codes_seen);
		$display("Covered all four layouts, generic widths 0 to 31, and zero and full bound and span.");
		if (mismatch_count == 0 && codes_pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/qs3c_pkg.sv
hw/rtl/qs3c_select.sv
hw/rtl/qs3c_lane.sv
hw/rtl/qs3c_pack.sv
hw/rtl/quat_smallest_three_compress_unit.sv
tb/quat_code_checker.sv
tb/quat_smallest_three_compress_unit_tb.sv
